// File: rtl/core/emq_pkg.sv
// shared types, constants and helpers for the exponential map to quaternion unit
`default_nettype none
package emq_pkg;

  typedef struct packed {
    logic [31:0] vec_x;
    logic [31:0] vec_y;
    logic [31:0] vec_z;
    logic        allow_reparam;
  } emq_in_t;

  typedef struct packed {
    logic [31:0] quat_w;
    logic [31:0] quat_x;
    logic [31:0] quat_y;
    logic [31:0] quat_z;
    logic [31:0] new_x;
    logic [31:0] new_y;
    logic [31:0] new_z;
    logic        was_reparam;
  } emq_out_t;

  // sign and magnitude of the three vector components
  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic             allow;
  } emq_src_t;

  // vector after the rewrite, with its angle
  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic             rep;
    logic [31:0]      theta;
  } emq_vec_t;

  typedef struct packed {
    emq_src_t    src;
    logic [31:0] theta0;
    logic        tneg;
    logic [31:0] tmag;
    logic        rep;
  } emq_d1_t;

  typedef struct packed {
    emq_vec_t           vec;
    logic signed [33:0] cosv;
    logic               sneg;
  } emq_d2_t;

  localparam logic [63:0] PI_Q60        = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_PI_Q60    = 64'h6487ED5110B4611A;
  localparam logic [63:0] MIN_ANGLE_Q60 = 64'd115292150461;
  localparam logic [63:0] INV_4PI_Q32   = 64'd341782638;
  localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
  localparam int unsigned CORDIC_STEPS = 30;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // sign and magnitude to a saturated two's complement word
  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic [63:0] m;
    logic [31:0] r;
    if (neg) begin
      m = (mag > 64'h80000000) ? 64'h80000000 : mag;
      r = ~m[31:0] + 32'd1;
    end else begin
      m = (mag > 64'h7FFFFFFF) ? 64'h7FFFFFFF : mag;
      r = m[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/emq_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module emq_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic [31:0] quo_o
);
  localparam int unsigned NSTEP = 32;

  logic [31:0] rem_q [NSTEP];
  logic [31:0] low_q [NSTEP];
  logic [31:0] quo_q [NSTEP];
  logic [31:0] den_q [NSTEP];

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    logic [31:0] rem_in, low_in, quo_in, den_in;
    logic [32:0] r, r2;
    logic        ge;
    if (j == 0) begin : g_first
      assign rem_in = num_i[63:32];
      assign low_in = num_i[31:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign low_in = low_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
    end
    always_comb begin
      r  = {rem_in, low_in[31]};
      ge = (r >= {1'b0, den_in});
      r2 = ge ? (r - {1'b0, den_in}) : r;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= r2[31:0];
        low_q[j] <= {low_in[30:0], 1'b0};
        quo_q[j] <= {quo_in[30:0], ge};
        den_q[j] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[NSTEP-1];
endmodule
`default_nettype wire

// File: rtl/core/exp_map_to_quaternion_unit.sv
// exponential map rotation vector to unit quaternion, deep pipeline
// throughput: one transaction per cycle while the skid entry is empty; set by the bit-per-stage square root,
//   divider and cordic pipelines, which all advance together
// a two-entry output buffer keeps input ready high while one result waits
// reset: asynchronous active-low rst_ni clears all stage valid bits and the output buffer valid flags
`default_nettype none
module exp_map_to_quaternion_unit #(
  parameter int unsigned VEC_FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  emq_pkg::emq_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output emq_pkg::emq_out_t  out_data_o
);
  import emq_pkg::*;

  // angle constants in units of 2^-F rad
  localparam int unsigned SHIFT60 = 60 - VEC_FRAC_BITS;
  localparam logic [63:0] PI_F =
    (PI_Q60 + (64'd1 << (SHIFT60 - 1))) >> SHIFT60;
  localparam logic [63:0] TWO_PI_F =
    (TWO_PI_Q60 + (64'd1 << (SHIFT60 - 1))) >> SHIFT60;
  localparam logic [63:0] TAYLOR_LIM =
    (MIN_ANGLE_Q60 + (64'd1 << SHIFT60) - 64'd1) >> SHIFT60;
  localparam logic [63:0] HALF_LSB = 64'd1 << (VEC_FRAC_BITS - 1);

  // quotient bits of theta0 / 2pi
  localparam int unsigned QB = 31 - VEC_FRAC_BITS;

  // stage map
  localparam int unsigned ST_SQRT0 = 3;
  localparam int unsigned ST_MOD0  = ST_SQRT0 + 32;
  localparam int unsigned ST_M1    = ST_MOD0 + QB;
  localparam int unsigned ST_D10   = ST_M1 + 3;
  localparam int unsigned ST_P1    = ST_D10 + 32;
  localparam int unsigned ST_C0    = ST_P1 + 2;
  localparam int unsigned ST_Q1    = ST_C0 + CORDIC_STEPS;
  localparam int unsigned ST_D20   = ST_Q1 + 3;
  localparam int unsigned NST      = ST_D20 + 32;

  logic           en;
  logic           in_fire;
  logic [NST-1:0] v_q;
  logic           ov_q, sv_q;
  emq_out_t       out_q, skid_q, res;

  // whole pipe moves unless the skid entry is occupied
  assign en         = !sv_q;
  assign in_ready_o = en;
  assign in_fire    = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_fire};
    end
  end

  // ---------------- input decode: sign and magnitude
  logic [2:0][31:0] in_vec;
  emq_src_t         src_d, src0_q;
  assign in_vec = {in_data_i.vec_z, in_data_i.vec_y, in_data_i.vec_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src_d.neg[i] = in_vec[i][31];
      src_d.mag[i] = in_vec[i][31] ? (~in_vec[i] + 32'd1) : in_vec[i];
    end
    src_d.allow = in_data_i.allow_reparam;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      src0_q <= src_d;
    end
  end

  // ---------------- squares and their sum
  logic [2:0][63:0] sq1_q;
  emq_src_t         src1_q, src2_q;
  logic [63:0]      sum2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq1_q[i] <= 64'(src0_q.mag[i]) * 64'(src0_q.mag[i]);
      end
      src1_q <= src0_q;
      sum2_q <= sq1_q[0] + sq1_q[1] + sq1_q[2];
      src2_q <= src1_q;
    end
  end

  // ---------------- integer square root, one root bit per stage
  logic [33:0] sr_rem_q  [32];
  logic [31:0] sr_root_q [32];
  logic [63:0] sr_n_q    [32];
  emq_src_t    sr_src_q  [32];

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] n_in;
    emq_src_t    src_in;
    logic [35:0] rs, trial;
    logic        ge;
    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = sum2_q;
      assign src_in  = src2_q;
    end else begin : g_next
      assign rem_in  = sr_rem_q[j-1];
      assign root_in = sr_root_q[j-1];
      assign n_in    = sr_n_q[j-1];
      assign src_in  = sr_src_q[j-1];
    end
    always_comb begin
      rs    = {rem_in, n_in[63:62]};
      trial = {2'b00, root_in, 2'b01};
      ge    = (rs >= trial);
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_rem_q[j]  <= ge ? 34'(rs - trial) : rs[33:0];
        sr_root_q[j] <= {root_in[30:0], ge};
        sr_n_q[j]    <= {n_in[61:0], 2'b00};
        sr_src_q[j]  <= src_in;
      end
    end
  end

  // ---------------- theta0 mod 2pi, restoring steps against shifted 2pi
  logic [31:0] md_t_q   [QB];
  logic [31:0] md_th_q  [QB];
  emq_src_t    md_src_q [QB];

  for (genvar m = 0; m < QB; m++) begin : g_mod
    localparam logic [33:0] LIM = TWO_PI_F[33:0] << (QB - 1 - m);
    logic [31:0] t_in, th_in;
    emq_src_t    src_in;
    if (m == 0) begin : g_first
      assign t_in   = sr_root_q[31];
      assign th_in  = sr_root_q[31];
      assign src_in = sr_src_q[31];
    end else begin : g_next
      assign t_in   = md_t_q[m-1];
      assign th_in  = md_th_q[m-1];
      assign src_in = md_src_q[m-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        md_t_q[m]   <= ({2'b00, t_in} >= LIM) ? (t_in - LIM[31:0]) : t_in;
        md_th_q[m]  <= th_in;
        md_src_q[m] <= src_in;
      end
    end
  end

  // ---------------- fold to the shorter angle, then scale numerators
  emq_d1_t          m1_q, m2_q, m3_q;
  logic [2:0][63:0] m2_prod_q, m3_num_q;
  logic [31:0]      t_mod;
  logic             t_gt_pi;
  logic [33:0]      t_fold;

  always_comb begin
    t_mod   = md_t_q[QB-1];
    t_gt_pi = ({32'd0, t_mod} > PI_F);
    t_fold  = TWO_PI_F[33:0] - {2'b00, t_mod};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q.src    <= md_src_q[QB-1];
      m1_q.theta0 <= md_th_q[QB-1];
      m1_q.tneg   <= t_gt_pi;
      m1_q.tmag   <= t_gt_pi ? t_fold[31:0] : t_mod;
      m1_q.rep    <= md_src_q[QB-1].allow && ({32'd0, md_th_q[QB-1]} > PI_F);
      for (int i = 0; i < 3; i++) begin
        m2_prod_q[i] <= 64'(m1_q.src.mag[i]) * 64'(m1_q.tmag);
        // round to nearest on the following division
        m3_num_q[i]  <= m2_prod_q[i] + 64'(m2_q.theta0[31:1]);
      end
      m2_q <= m1_q;
      m3_q <= m2_q;
    end
  end

  // ---------------- new vector = v * s / theta0
  logic [2:0][31:0] d1_quo;
  emq_d1_t          d1_q [32];

  for (genvar i = 0; i < 3; i++) begin : g_div1
    emq_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (m3_num_q[i]),
      .den_i (m3_q.theta0),
      .quo_o (d1_quo[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0] <= m3_q;
      for (int j = 1; j < 32; j++) begin
        d1_q[j] <= d1_q[j-1];
      end
    end
  end

  // ---------------- pick rewritten or original vector
  emq_vec_t vec_d, p1_q, p2_q;
  logic     nn;

  always_comb begin
    vec_d.rep   = d1_q[31].rep;
    vec_d.theta = d1_q[31].rep ? d1_q[31].tmag : d1_q[31].theta0;
    for (int i = 0; i < 3; i++) begin
      nn = (d1_quo[i] != '0) && (d1_q[31].src.neg[i] != d1_q[31].tneg);
      if (d1_q[31].rep) begin
        vec_d.neg[i] = nn;
        if (nn) begin
          vec_d.mag[i] = (d1_quo[i] > 32'h80000000) ? 32'h80000000 : d1_quo[i];
        end else begin
          vec_d.mag[i] = (d1_quo[i] > 32'h7FFFFFFF) ? 32'h7FFFFFFF : d1_quo[i];
        end
      end else begin
        vec_d.neg[i] = d1_q[31].src.neg[i];
        vec_d.mag[i] = d1_q[31].src.mag[i];
      end
    end
  end

  // phase in turns of the half angle, with 32 + VEC_FRAC_BITS fraction bits
  logic [63:0] ph_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= vec_d;
      ph_q <= 64'(p1_q.theta) * INV_4PI_Q32;
      p2_q <= p1_q;
    end
  end

  // ---------------- rotation-mode cordic over one quarter turn
  logic signed [33:0] cx_q [CORDIC_STEPS];
  logic signed [33:0] cy_q [CORDIC_STEPS];
  logic signed [31:0] cz_q [CORDIC_STEPS];
  logic [1:0]         cq_q [CORDIC_STEPS];
  emq_vec_t           cv_q [CORDIC_STEPS];

  for (genvar c = 0; c < CORDIC_STEPS; c++) begin : g_cordic
    logic signed [33:0] x_in, y_in, dx, dy;
    logic signed [31:0] z_in, at;
    logic [1:0]         q_in;
    emq_vec_t           v_in;
    if (c == 0) begin : g_first
      assign x_in = CORDIC_K_Q30;
      assign y_in = '0;
      assign z_in = $signed({2'b00, ph_q[VEC_FRAC_BITS +: 30]});
      assign q_in = ph_q[VEC_FRAC_BITS + 30 +: 2];
      assign v_in = p2_q;
    end else begin : g_next
      assign x_in = cx_q[c-1];
      assign y_in = cy_q[c-1];
      assign z_in = cz_q[c-1];
      assign q_in = cq_q[c-1];
      assign v_in = cv_q[c-1];
    end
    assign dx = y_in >>> c;
    assign dy = x_in >>> c;
    assign at = $signed(ATAN_TURNS[c]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (z_in >= 0) begin
          cx_q[c] <= x_in - dx;
          cy_q[c] <= y_in + dy;
          cz_q[c] <= z_in - at;
        end else begin
          cx_q[c] <= x_in + dx;
          cy_q[c] <= y_in - dy;
          cz_q[c] <= z_in + at;
        end
        cq_q[c] <= q_in;
        cv_q[c] <= v_in;
      end
    end
  end

  // ---------------- quadrant fix-up, then v * sin / theta numerators
  logic signed [33:0] cos_d, sin_d, sin_abs;
  emq_d2_t            q1_q, q2_q, q3_q;
  logic [31:0]        q1_smag_q;
  logic [2:0][63:0]   q2_prod_q, q3_num_q;

  always_comb begin
    case (cq_q[CORDIC_STEPS-1])
      QUAD_0: begin
        cos_d = cx_q[CORDIC_STEPS-1];
        sin_d = cy_q[CORDIC_STEPS-1];
      end
      QUAD_1: begin
        cos_d = -cy_q[CORDIC_STEPS-1];
        sin_d = cx_q[CORDIC_STEPS-1];
      end
      QUAD_2: begin
        cos_d = -cx_q[CORDIC_STEPS-1];
        sin_d = -cy_q[CORDIC_STEPS-1];
      end
      default: begin
        cos_d = cy_q[CORDIC_STEPS-1];
        sin_d = -cx_q[CORDIC_STEPS-1];
      end
    endcase
    sin_abs = (sin_d < 0) ? -sin_d : sin_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_q.vec  <= cv_q[CORDIC_STEPS-1];
      q1_q.cosv <= cos_d;
      q1_q.sneg <= (sin_d < 0);
      q1_smag_q <= sin_abs[31:0];
      for (int i = 0; i < 3; i++) begin
        q2_prod_q[i] <= 64'(q1_q.vec.mag[i]) * 64'(q1_smag_q);
        q3_num_q[i]  <= q2_prod_q[i] + 64'(q2_q.vec.theta[31:1]);
      end
      q2_q <= q1_q;
      q3_q <= q2_q;
    end
  end

  // ---------------- quaternion vector part division
  logic [2:0][31:0] d2_quo;
  emq_d2_t          d2_q [32];

  for (genvar i = 0; i < 3; i++) begin : g_div2
    emq_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (q3_num_q[i]),
      .den_i (q3_q.vec.theta),
      .quo_o (d2_quo[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q[0] <= q3_q;
      for (int j = 1; j < 32; j++) begin
        d2_q[j] <= d2_q[j-1];
      end
    end
  end

  // ---------------- result formatting; tiny angles use the half-vector form
  emq_d2_t          fin;
  logic             small_ang;
  logic [33:0]      cos_abs;
  logic [2:0][63:0] qm;
  logic [2:0]       qn;
  logic [2:0][31:0] quat_v, new_v;

  always_comb begin
    fin       = d2_q[31];
    small_ang = ({32'd0, fin.vec.theta} < TAYLOR_LIM);
    cos_abs   = fin.cosv[33] ? 34'(-fin.cosv) : 34'(fin.cosv);
    for (int i = 0; i < 3; i++) begin
      if (small_ang) begin
        qm[i] = ((64'(fin.vec.mag[i]) << 29) + HALF_LSB) >> VEC_FRAC_BITS;
        qn[i] = fin.vec.neg[i];
      end else begin
        qm[i] = 64'(d2_quo[i]);
        qn[i] = fin.vec.neg[i] != fin.sneg;
      end
      quat_v[i] = sat32(qn[i] && (qm[i] != '0), qm[i]);
      new_v[i]  = sat32(fin.vec.neg[i], 64'(fin.vec.mag[i]));
    end
    res.quat_w      = sat32(fin.cosv[33], 64'(cos_abs));
    res.quat_x      = quat_v[0];
    res.quat_y      = quat_v[1];
    res.quat_z      = quat_v[2];
    res.new_x       = new_v[0];
    res.new_y       = new_v[1];
    res.new_z       = new_v[2];
    res.was_reparam = fin.vec.rep;
  end

  // ---------------- output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (en && v_q[NST-1]) begin
      if (!ov_q || out_ready_i) begin
        ov_q <= 1'b1;
      end else begin
        sv_q <= 1'b1;
      end
    end else if (ov_q && out_ready_i) begin
      if (sv_q) begin
        sv_q <= 1'b0;
      end else begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v_q[NST-1]) begin
      if (!ov_q || out_ready_i) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (ov_q && out_ready_i && sv_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q) else $error("skid full with no output");

  // a finished transaction meeting a stalled output lands in the skid entry
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i && !sv_q && v_q[NST-1]) |=> sv_q)
    else $error("result dropped at stalled output");

  // angle reduction leaves a value below 2pi
  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_M1-1] |-> ({32'd0, md_t_q[QB-1]} < TWO_PI_F))
    else $error("angle reduction out of range");

  // rewritten angle never exceeds pi
  a_rep_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_P1] && p1_q.rep) |-> ({32'd0, p1_q.theta} <= PI_F))
    else $error("rewritten angle above pi");
`endif

endmodule
`default_nettype wire
